[hw/rtl/information_frame_receiver_assert.svh]
// Assertion macros shared by the frame receiver RTL.
// Included by ifr_core and information_frame_receiver; no other dependencies.
`ifndef INFORMATION_FRAME_RECEIVER_ASSERT_SVH
`define INFORMATION_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ifr assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define IFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ifr assertion failed: next-cycle implication");

`endif

[hw/rtl/ifr_pkg.sv]
// Package for the information frame receiver: codes, limits and shared types.
// Used by ifr_csr, ifr_core and information_frame_receiver.
`default_nettype none

package ifr_pkg;

   // Payload bound and stuffing mask
   localparam logic [11:0] MAX_PAYLOAD = 12'd2048;
   localparam logic [7:0]  STUFF_MASK  = 8'h20;

   // Control register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC    = 3'd5;

   // Register reset values
   localparam logic [7:0] RST_FLAG    = 8'h7E;
   localparam logic [7:0] RST_ESCAPE  = 8'h7D;
   localparam logic [7:0] RST_ADDRESS = 8'h03;
   localparam logic [7:0] RST_SEQ0    = 8'h00;
   localparam logic [7:0] RST_SEQ1    = 8'h80;
   localparam logic [7:0] RST_DISC    = 8'h0B;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_FLAG = 3'd1,
      PH_ADDR = 3'd2,
      PH_CTRL = 3'd3,
      PH_DATA = 3'd4,
      PH_ESC  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_BYTE   = 3'd1,
      EV_ACCEPT = 3'd2,
      EV_REJECT = 3'd3,
      EV_DUP    = 3'd4,
      EV_DISC   = 3'd5,
      EV_OVER   = 3'd6
   } event_type;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
      logic [7:0] address_byte;
      logic [7:0] seq0_code;
      logic [7:0] seq1_code;
      logic [7:0] disc_code;
   } cfg_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  out_byte;
      logic        ack_seq;
      logic [11:0] payload_length;
   } res_type;

endpackage

`default_nettype wire

[hw/rtl/information_frame_receiver.sv]
// Information frame receiver: one line byte per request transaction, one event per response.
// Byte N enters the request channel; the response carries the event it caused.
// A byte accepted at a clock edge is written into the input register, and its response
// is written into the result register when the frame state steps; a new byte is taken every
// cycle while the response side keeps up. Sustained rate is one byte per clock while
// rsp_stall stays low, set by the frame state update between the registers.
// Each request transaction yields exactly one response transaction, event
// none included. A payload byte is released one byte late; the last byte of
// a frame is the XOR check and is never released. At the closing flag the
// response reports accepted, rejected or duplicate with the sequence to
// acknowledge and the payload length.
// Reset (synchronous) empties both registers, restores the control register
// values and sends the receiver hunting for an opening flag.
// When rsp_stall is high the result register holds; the input register still takes one more
// byte, then req_stall rises until the result drains. The user writes control registers
// through csr_* only while no bytes are in flight; the block does not enforce it.
// Depends on ifr_pkg, ifr_csr, ifr_core and information_frame_receiver_assert.svh.
`default_nettype none

module information_frame_receiver
   import ifr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_byte,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_event_res,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_ack_seq,
   output logic [11:0]               rsp_payload_length,
   // control register writes
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata
);

   cfg_type    cfg;
   res_type    res;
   res_type    rsp_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       step;
   logic       req_take;

   // Pipeline handshake
   assign step      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   ifr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ifr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_out_byte       = rsp_ff.out_byte;
   assign rsp_ack_seq        = rsp_ff.ack_seq;
   assign rsp_payload_length = rsp_ff.payload_length;

   // Checks
   `include "information_frame_receiver_assert.svh"

   `IFR_ASSERT_IMP(a_stall_needs_item, clock, reset, req_stall, in_valid_ff)
   `IFR_ASSERT_NXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)
   `IFR_ASSERT_IMP(a_byte_fields, clock, reset,
      rsp_valid_ff && (rsp_ff.event_res == EV_BYTE),
      !rsp_ff.ack_seq && (rsp_ff.payload_length == 12'd0))

endmodule

`default_nettype wire

[hw/rtl/ifr_csr.sv]
// Control registers of the frame receiver: delimiter, escape, address and control codes.
// Depends on ifr_pkg.
`default_nettype none

module ifr_csr
   import ifr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;

   // Register file; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte    <= RST_FLAG;
         cfg_ff.escape_byte  <= RST_ESCAPE;
         cfg_ff.address_byte <= RST_ADDRESS;
         cfg_ff.seq0_code    <= RST_SEQ0;
         cfg_ff.seq1_code    <= RST_SEQ1;
         cfg_ff.disc_code    <= RST_DISC;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FLAG:    cfg_ff.flag_byte    <= csr_wdata;
            CSR_ESCAPE:  cfg_ff.escape_byte  <= csr_wdata;
            CSR_ADDRESS: cfg_ff.address_byte <= csr_wdata;
            CSR_SEQ0:    cfg_ff.seq0_code    <= csr_wdata;
            CSR_SEQ1:    cfg_ff.seq1_code    <= csr_wdata;
            CSR_DISC:    cfg_ff.disc_code    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/ifr_core.sv]
// Frame state machine: header hunt, destuffing, hold-back of the check byte, verdict.
// Depends on ifr_pkg and information_frame_receiver_assert.svh.
`default_nettype none

module ifr_core
   import ifr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,      // process rx_byte this cycle
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output res_type         res
);

   phase_type   phase_ff, phase_in;
   logic        last_seq_ff, last_seq_in;
   logic        seq_known_ff, seq_known_in;
   logic        dup_ff, dup_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  xor_ff, xor_in;
   logic [11:0] count_ff, count_in;

   logic        is_flag;
   logic        is_esc;
   logic        is_seq0;
   logic        is_seq1;
   logic [7:0]  hdr_check;
   logic [7:0]  data_byte;
   logic        over;

   // Byte classification
   assign is_flag   = (rx_byte == cfg.flag_byte);
   assign is_esc    = (rx_byte == cfg.escape_byte);
   assign is_seq0   = (rx_byte == cfg.seq0_code);
   assign is_seq1   = (rx_byte == cfg.seq1_code);
   assign hdr_check = cfg.address_byte ^ (last_seq_ff ? cfg.seq1_code : cfg.seq0_code);
   assign data_byte = (phase_ff == PH_ESC) ? (rx_byte ^ STUFF_MASK) : rx_byte;
   // A held byte would be emitted but the payload is already full
   assign over      = held_valid_ff && (count_ff >= MAX_PAYLOAD);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: if (is_flag) phase_in = PH_FLAG;
         PH_FLAG: begin
            if (rx_byte == cfg.address_byte) phase_in = PH_ADDR;
            else if (!is_flag)               phase_in = PH_HUNT;
         end
         PH_ADDR: begin
            if (is_seq0 || is_seq1) phase_in = PH_CTRL;
            else if (is_flag)       phase_in = PH_FLAG;
            else                    phase_in = PH_HUNT;
         end
         PH_CTRL: begin
            if (rx_byte == hdr_check) phase_in = PH_DATA;
            else if (is_flag)         phase_in = PH_FLAG;
            else                      phase_in = PH_HUNT;
         end
         PH_DATA: begin
            if (is_esc)       phase_in = PH_ESC;
            else if (is_flag) phase_in = PH_FLAG;
            else if (over)    phase_in = PH_HUNT;
         end
         PH_ESC: begin
            if (is_flag)   phase_in = PH_FLAG;
            else if (over) phase_in = PH_HUNT;
            else           phase_in = PH_DATA;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // Result and frame bookkeeping
   always_comb begin
      logic open_frame;
      logic take_data;

      open_frame         = 1'b0;
      take_data          = 1'b0;
      res.event_res      = EV_NONE;
      res.out_byte       = 8'd0;
      res.ack_seq        = 1'b0;
      res.payload_length = 12'd0;
      last_seq_in        = last_seq_ff;
      seq_known_in       = seq_known_ff;
      dup_in             = dup_ff;
      held_byte_in       = held_byte_ff;
      held_valid_in      = held_valid_ff;
      xor_in             = xor_ff;
      count_in           = count_ff;

      unique case (phase_ff)
         PH_HUNT: open_frame = is_flag;
         PH_FLAG: ;
         PH_ADDR: begin
            if (is_seq0 || is_seq1) begin
               // sequence 0 wins when both codes match
               last_seq_in  = !is_seq0;
               dup_in       = seq_known_ff && ((!is_seq0) == last_seq_ff);
               seq_known_in = 1'b1;
            end else if (is_flag) begin
               open_frame = 1'b1;
            end else if (rx_byte == cfg.disc_code) begin
               res.event_res = EV_DISC;
            end
         end
         PH_CTRL: open_frame = (rx_byte != hdr_check) && is_flag;
         PH_DATA: begin
            if (is_esc) begin
               // nothing until the escaped byte arrives
            end else if (is_flag) begin
               res.payload_length = count_ff;
               if (!held_valid_ff) begin
                  res.event_res = EV_REJECT;
                  res.ack_seq   = last_seq_ff;
               end else if (dup_ff) begin
                  res.event_res = EV_DUP;
                  res.ack_seq   = !last_seq_ff;
               end else if (held_byte_ff == xor_ff) begin
                  res.event_res = EV_ACCEPT;
                  res.ack_seq   = !last_seq_ff;
               end else begin
                  res.event_res = EV_REJECT;
                  res.ack_seq   = last_seq_ff;
               end
               open_frame = 1'b1;
            end else begin
               take_data = 1'b1;
            end
         end
         PH_ESC: begin
            if (is_flag) begin
               // escaped flag aborts the frame
               res.event_res      = EV_REJECT;
               res.ack_seq        = last_seq_ff;
               res.payload_length = count_ff;
               open_frame         = 1'b1;
            end else begin
               take_data = 1'b1;
            end
         end
         default: ;
      endcase

      // Destuffed byte: emit the held one and hold the new one, or report overflow when full
      if (take_data) begin
         if (over) begin
            res.event_res      = EV_OVER;
            res.ack_seq        = last_seq_ff;
            res.payload_length = count_ff;
            held_valid_in      = 1'b0;
         end else begin
            if (held_valid_ff) begin
               res.event_res = EV_BYTE;
               res.out_byte  = held_byte_ff;
               xor_in        = xor_ff ^ held_byte_ff;
               count_in      = count_ff + 12'd1;
            end
            held_byte_in  = data_byte;
            held_valid_in = 1'b1;
         end
      end

      if (open_frame) begin
         held_byte_in  = 8'd0;
         held_valid_in = 1'b0;
         xor_in        = 8'd0;
         count_in      = 12'd0;
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         last_seq_ff   <= 1'b0;
         seq_known_ff  <= 1'b0;
         dup_ff        <= 1'b0;
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         xor_ff        <= 8'd0;
         count_ff      <= 12'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         last_seq_ff   <= last_seq_in;
         seq_known_ff  <= seq_known_in;
         dup_ff        <= dup_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         count_ff      <= count_in;
      end
   end

   // Checks
   `include "information_frame_receiver_assert.svh"

   `IFR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_PAYLOAD)
   `IFR_ASSERT_NXT(a_count_hold, clock, reset, !step, count_ff == $past(count_ff))
   `IFR_ASSERT_IMP(a_over_needs_held, clock, reset, res.event_res == EV_OVER, held_valid_ff)

endmodule

`default_nettype wire

[test/tb_information_frame_receiver.sv]
// Self-checking testbench for the information frame receiver: framing, destuffing,
// header and XOR check, duplicates and disconnect, under several register sets.
// Depends on ifr_pkg and the information_frame_receiver RTL.
`default_nettype none

module tb_information_frame_receiver
   import ifr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the register list; writes to them must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_event_res;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_ack_seq;
   logic [11:0]          rsp_payload_length;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = 8'h00;

   information_frame_receiver uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_ack_seq        (rsp_ack_seq),
      .rsp_payload_length (rsp_payload_length),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver model: register copy and frame state
   cfg_type     regs;
   phase_type   rx_phase;
   logic        rx_last_seq;
   logic        rx_seq_known;
   logic        rx_dup;
   logic [7:0]  rx_held;
   logic        rx_held_ok;
   logic [7:0]  rx_xor;
   logic [11:0] rx_count;

   logic [7:0]  line_bytes [$];       // line bytes waiting to be sent
   res_type     expected_events [$];  // one predicted event per accepted byte
   int unsigned mismatches = 0;

   function automatic res_type make_event(input event_type ev, input logic [7:0] ob,
                                          input logic ack, input logic [11:0] len);
      res_type r;
      r.event_res      = ev;
      r.out_byte       = ob;
      r.ack_seq        = ack;
      r.payload_length = len;
      return r;
   endfunction

   function void open_frame();
      rx_phase   = PH_FLAG;
      rx_held    = 8'h00;
      rx_held_ok = 1'b0;
      rx_xor     = 8'h00;
      rx_count   = 12'd0;
   endfunction

   // Destuffed byte: release the held one, keep the new one as possible check byte
   function automatic res_type take_data(input logic [7:0] d);
      res_type r;
      r = make_event(EV_NONE, 8'h00, 1'b0, 12'd0);
      if (rx_held_ok) begin
         if (rx_count >= MAX_PAYLOAD) begin
            rx_phase   = PH_HUNT;
            rx_held_ok = 1'b0;
            return make_event(EV_OVER, 8'h00, rx_last_seq, rx_count);
         end
         r = make_event(EV_BYTE, rx_held, 1'b0, 12'd0);
         rx_xor   = rx_xor ^ rx_held;
         rx_count = rx_count + 12'd1;
      end
      rx_held    = d;
      rx_held_ok = 1'b1;
      return r;
   endfunction

   function automatic res_type next_event(input logic [7:0] b);
      res_type    r;
      logic [7:0] ctrl;
      logic       s;
      r = make_event(EV_NONE, 8'h00, 1'b0, 12'd0);
      case (rx_phase)
         PH_HUNT: begin
            if (b == regs.flag_byte) open_frame();
         end
         PH_FLAG: begin
            if (b == regs.address_byte) rx_phase = PH_ADDR;
            else if (b != regs.flag_byte) rx_phase = PH_HUNT;
         end
         PH_ADDR: begin
            // sequence codes win over flag, flag over disconnect
            if (b == regs.seq0_code || b == regs.seq1_code) begin
               s            = (b == regs.seq0_code) ? 1'b0 : 1'b1;
               rx_dup       = rx_seq_known && (s == rx_last_seq);
               rx_last_seq  = s;
               rx_seq_known = 1'b1;
               rx_phase     = PH_CTRL;
            end else if (b == regs.flag_byte) begin
               open_frame();
            end else if (b == regs.disc_code) begin
               r        = make_event(EV_DISC, 8'h00, 1'b0, 12'd0);
               rx_phase = PH_HUNT;
            end else begin
               rx_phase = PH_HUNT;
            end
         end
         PH_CTRL: begin
            ctrl = rx_last_seq ? regs.seq1_code : regs.seq0_code;
            if (b == (regs.address_byte ^ ctrl)) rx_phase = PH_DATA;
            else if (b == regs.flag_byte) open_frame();
            else rx_phase = PH_HUNT;
         end
         PH_DATA: begin
            if (b == regs.escape_byte) begin
               rx_phase = PH_ESC;
            end else if (b == regs.flag_byte) begin
               // verdict: empty, duplicate, then check byte against running XOR
               if (!rx_held_ok)
                  r = make_event(EV_REJECT, 8'h00, rx_last_seq, rx_count);
               else if (rx_dup)
                  r = make_event(EV_DUP, 8'h00, ~rx_last_seq, rx_count);
               else if (rx_held == rx_xor)
                  r = make_event(EV_ACCEPT, 8'h00, ~rx_last_seq, rx_count);
               else
                  r = make_event(EV_REJECT, 8'h00, rx_last_seq, rx_count);
               open_frame();
            end else begin
               r = take_data(b);
            end
         end
         PH_ESC: begin
            if (b == regs.flag_byte) begin
               r = make_event(EV_REJECT, 8'h00, rx_last_seq, rx_count);
               open_frame();
            end else begin
               rx_phase = PH_DATA;
               r = take_data(b ^ STUFF_MASK);
            end
         end
         default: rx_phase = PH_HUNT;
      endcase
      return r;
   endfunction

   // Stimulus builders, all using the current register copy
   function void push_stuffed(input logic [7:0] d);
      if (d == regs.flag_byte || d == regs.escape_byte) begin
         line_bytes.push_back(regs.escape_byte);
         line_bytes.push_back(d ^ STUFF_MASK);
      end else begin
         line_bytes.push_back(d);
      end
   endfunction

   function void push_header(input logic [7:0] ctrl);
      line_bytes.push_back(regs.flag_byte);
      line_bytes.push_back(regs.address_byte);
      line_bytes.push_back(ctrl);
      line_bytes.push_back(regs.address_byte ^ ctrl);
   endfunction

   function void queue_frame(input logic [7:0] ctrl, input int unsigned body_len,
                             input bit bad_check);
      logic [7:0] data;
      logic [7:0] chk;
      chk = 8'h00;
      push_header(ctrl);
      repeat (body_len) begin
         // bias toward bytes that need stuffing
         case ($urandom_range(0, 7))
            0: data = regs.flag_byte;
            1: data = regs.escape_byte;
            2: data = regs.flag_byte ^ STUFF_MASK;
            default: data = 8'($urandom_range(0, 255));
         endcase
         chk = chk ^ data;
         push_stuffed(data);
      end
      if (bad_check) chk = chk ^ (8'h01 << $urandom_range(0, 7));
      push_stuffed(chk);
      line_bytes.push_back(regs.flag_byte);
   endfunction

   // Mostly well-formed frames, some aborted, broken or empty, some line noise
   function void queue_traffic(input int unsigned amount);
      int unsigned stop_at;
      logic [7:0]  ctrl;
      stop_at = line_bytes.size() + amount;
      while (line_bytes.size() < stop_at) begin
         ctrl = $urandom_range(0, 1) ? regs.seq1_code : regs.seq0_code;
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6, 7, 8: queue_frame(ctrl, $urandom_range(0, 12), 1'b0);
            9, 10: queue_frame(ctrl, $urandom_range(0, 12), 1'b1);
            11: begin
               // abort with an escaped flag
               push_header(ctrl);
               repeat ($urandom_range(0, 4)) push_stuffed(8'($urandom_range(0, 255)));
               line_bytes.push_back(regs.escape_byte);
               line_bytes.push_back(regs.flag_byte);
            end
            12: begin
               line_bytes.push_back(regs.flag_byte);
               line_bytes.push_back(regs.address_byte);
               if ($urandom_range(0, 1)) line_bytes.push_back(ctrl);
               line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            13: begin
               line_bytes.push_back(regs.flag_byte);
               line_bytes.push_back(regs.address_byte);
               line_bytes.push_back(regs.disc_code);
            end
            14: begin
               push_header(ctrl);
               line_bytes.push_back(regs.flag_byte);
            end
            default: begin
               repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
   endfunction

   function automatic cfg_type distinct_codes(input bit allow_clash);
      logic [7:0] v [6];
      bit         clash;
      for (int i = 0; i < 6; i++) begin
         do begin
            v[i]  = 8'($urandom_range(0, 255));
            clash = 1'b0;
            for (int j = 0; j < i; j++) if (v[j] == v[i]) clash = 1'b1;
         end while (clash && !allow_clash);
      end
      return '{v[0], v[1], v[2], v[3], v[4], v[5]};
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FLAG:    regs.flag_byte    = value;
         CSR_ESCAPE:  regs.escape_byte  = value;
         CSR_ADDRESS: regs.address_byte = value;
         CSR_SEQ0:    regs.seq0_code    = value;
         CSR_SEQ1:    regs.seq1_code    = value;
         CSR_DISC:    regs.disc_code    = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait until every byte is sent and every event has been checked
   task automatic wait_idle();
      @(negedge clock);
      while (line_bytes.size() != 0 || req_valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Driver: one byte per transaction, random gaps with gap-free bursts
   int unsigned send_wait = 0;
   bit          send_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (req_valid && !req_stall) begin
         expected_events.push_back(next_event(req_rx_byte));
         if ($urandom_range(0, 11) == 0) send_burst = !send_burst;
         send_wait = send_burst ? 0 : $urandom_range(0, 13);
         if (send_wait == 0 && line_bytes.size() != 0) req_rx_byte <= line_bytes.pop_front();
         else req_valid <= 1'b0;
      end else if (!req_valid) begin
         if (send_wait != 0) begin
            send_wait--;
         end else if (line_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= line_bytes.pop_front();
         end
      end
   end

   function void check_field(input string name, input logic [11:0] want, input logic [11:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: checks each event, stalls at random, and holds off once for a long stretch
   int unsigned hold_left = 0;
   int unsigned checked_count = 0;
   bit          recv_burst = 1'b0;
   res_type     want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: event_res expected no transaction actual %0d",
                        $time, rsp_event_res);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", 12'(want.event_res), 12'(rsp_event_res));
               check_field("out_byte", 12'(want.out_byte), 12'(rsp_out_byte));
               check_field("ack_seq", 12'(want.ack_seq), 12'(rsp_ack_seq));
               check_field("payload_length", want.payload_length, rsp_payload_length);
            end
            checked_count++;
            if (checked_count == 120) begin
               hold_left = 300;
            end else begin
               if ($urandom_range(0, 11) == 0) recv_burst = !recv_burst;
               hold_left = recv_burst ? 0 : $urandom_range(0, 13);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: reset, directed frames and traffic, then one traffic phase per register set
   initial begin
      logic [7:0] flg, adr, s0, s1, esc, dsc;
      logic [7:0] directed [34];
      cfg_type    plan [6];

      regs = '{RST_FLAG, RST_ESCAPE, RST_ADDRESS, RST_SEQ0, RST_SEQ1, RST_DISC};
      rx_phase     = PH_HUNT;
      rx_last_seq  = 1'b0;
      rx_seq_known = 1'b0;
      rx_dup       = 1'b0;
      rx_held      = 8'h00;
      rx_held_ok   = 1'b0;
      rx_xor       = 8'h00;
      rx_count     = 12'd0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      flg = RST_FLAG;
      adr = RST_ADDRESS;
      s0  = RST_SEQ0;
      s1  = RST_SEQ1;
      esc = RST_ESCAPE;
      dsc = RST_DISC;
      // empty frame; check byte only; bad check after an escape; disconnect;
      // repeated flag with escaped-flag abort; duplicate; bad control byte
      directed = '{flg, adr, s0, adr ^ s0, flg,
                   adr, s1, adr ^ s1, 8'h00, flg,
                   adr, s0, adr ^ s0, esc, esc ^ STUFF_MASK, flg,
                   adr, dsc,
                   flg, flg, adr, s0, adr ^ s0, 8'hFF, esc, flg,
                   adr, s0, adr ^ s0, 8'h11, 8'h11, flg,
                   adr, 8'hFF};

      @(negedge clock);
      foreach (directed[i]) line_bytes.push_back(directed[i]);
      queue_traffic(70);

      plan[0] = '{8'h00, 8'hFF, 8'h81, 8'h7F, 8'h01, 8'hFE};
      plan[1] = '{8'hFF, 8'h01, 8'h00, 8'hFE, 8'h80, 8'h7F};
      plan[2] = '{8'h10, 8'h30, 8'hC3, 8'h3C, 8'h00, 8'hFF};
      plan[3] = distinct_codes(1'b0);
      plan[4] = distinct_codes(1'b1);
      plan[5] = '{RST_FLAG, RST_ESCAPE, RST_ADDRESS, RST_SEQ0, RST_SEQ1, RST_DISC};

      foreach (plan[p]) begin
         wait_idle();
         write_reg(CSR_FLAG, plan[p].flag_byte);
         write_reg(CSR_ESCAPE, plan[p].escape_byte);
         write_reg(CSR_ADDRESS, plan[p].address_byte);
         write_reg(CSR_SEQ0, plan[p].seq0_code);
         write_reg(CSR_SEQ1, plan[p].seq1_code);
         write_reg(CSR_DISC, plan[p].disc_code);
         if (p == 4) begin
            write_reg(CSR_SPARE_LO, 8'($urandom_range(0, 255)));
            write_reg(CSR_SPARE_HI, 8'($urandom_range(0, 255)));
         end
         @(negedge clock);
         queue_traffic(70);
      end

      wait_idle();
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/ifr_pkg.sv
hw/rtl/ifr_csr.sv
hw/rtl/ifr_core.sv
hw/rtl/information_frame_receiver.sv
test/tb_information_frame_receiver.sv
